FILE: design/qasu_pkg.sv
// shared constants, types and helpers for the spin update block
package qasu_pkg;

    localparam int MAX_SPINS    = 64;
    localparam int MAX_REPLICAS = 8;
    localparam int SPIN_W       = $clog2(MAX_SPINS);
    localparam int REP_W        = $clog2(MAX_REPLICAS);
    localparam int SCNT_W       = 7;
    localparam int TCNT_W       = 4;
    localparam int COUP_AW      = 2 * SPIN_W;

    typedef enum logic [2:0] {
        KIND_WR_COUP  = 3'd0,
        KIND_WR_FIELD = 3'd1,
        KIND_WR_SPIN  = 3'd2,
        KIND_UPDATE   = 3'd3,
        KIND_RD_SPIN  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        CFG_TROTTER = 2'd0,
        CFG_SPINS   = 2'd1,
        CFG_JPERP   = 2'd2,
        CFG_BETA    = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_WCOUP,
        S_WFIELD,
        S_RROW,
        S_WSPIN,
        S_RDCAP,
        S_UUP,
        S_UDN,
        S_UACC,
        S_UTUN,
        S_UDBL,
        S_UMUL,
        S_UCMP,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic rd_row;
        logic rd_up;
        logic rd_dn;
        logic cap_row;
        logic cap_su;
        logic acc_start;
        logic acc;
        logic tun;
        logic dbl;
        logic mul;
        logic cmp;
        logic wr_coup;
        logic wr_field;
        logic wr_spin;
        logic cap_read;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [2:0] kind;
        logic       in_range;
        logic       last;
    } t_stat;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] res;
        if (v > 34'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -34'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

FILE: design/qasu_ctrl.sv
// sequencer for spin store access and metropolis update steps
module qasu_ctrl import qasu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_stat.kind)
                    KIND_WR_COUP:  n_state = S_WCOUP;
                    KIND_WR_FIELD: n_state = S_WFIELD;
                    KIND_WR_SPIN,
                    KIND_UPDATE,
                    KIND_RD_SPIN:  n_state = S_RROW;
                    default:       n_state = S_OUT;
                endcase
            end
            S_WCOUP: begin
                o_cmd.wr_coup = 1'b1;
                n_state       = S_OUT;
            end
            S_WFIELD: begin
                o_cmd.wr_field = 1'b1;
                n_state        = S_OUT;
            end
            S_RROW: begin
                o_cmd.rd_row = 1'b1;
                if (i_stat.kind == KIND_WR_SPIN) begin
                    n_state = S_WSPIN;
                end else if (i_stat.kind == KIND_UPDATE && i_stat.in_range) begin
                    n_state = S_UUP;
                end else begin
                    n_state = S_RDCAP;
                end
            end
            S_WSPIN: begin
                o_cmd.wr_spin = 1'b1;
                n_state       = S_OUT;
            end
            S_RDCAP: begin
                o_cmd.cap_read = 1'b1;
                n_state        = S_OUT;
            end
            S_UUP: begin
                o_cmd.cap_row = 1'b1;
                o_cmd.rd_up   = 1'b1;
                n_state       = S_UDN;
            end
            S_UDN: begin
                o_cmd.cap_su    = 1'b1;
                o_cmd.rd_dn     = 1'b1;
                o_cmd.acc_start = 1'b1;
                n_state         = S_UACC;
            end
            S_UACC: begin
                o_cmd.acc = 1'b1;
                if (i_stat.last) begin
                    n_state = S_UTUN;
                end
            end
            S_UTUN: begin
                o_cmd.tun = 1'b1;
                n_state   = S_UDBL;
            end
            S_UDBL: begin
                o_cmd.dbl = 1'b1;
                n_state   = S_UMUL;
            end
            S_UMUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_UCMP;
            end
            S_UCMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: design/qasu_dp.sv
// stores, energy accumulator and flip test
module qasu_dp import qasu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic [2:0]         i_kind,
    input  logic [SPIN_W-1:0]  i_spin_index,
    input  logic [SPIN_W-1:0]  i_partner_index,
    input  logic [REP_W-1:0]   i_replica_index,
    input  logic signed [15:0] i_load_value,
    input  logic signed [23:0] i_log_random,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    output logic               o_spin_value,
    output logic               o_flipped
);

    // configuration
    logic [TCNT_W-1:0]  r_tcnt;
    logic [SCNT_W-1:0]  r_scnt;
    logic signed [15:0] r_jperp;
    logic [15:0]        r_beta;

    // latched item
    logic [2:0]         r_kind;
    logic [SPIN_W-1:0]  r_si;
    logic [SPIN_W-1:0]  r_pi;
    logic [REP_W-1:0]   r_ri;
    logic signed [15:0] r_lv;
    logic signed [23:0] r_rnd;

    // stores
    logic signed [15:0]   r_coup_mem [MAX_SPINS*MAX_SPINS];
    logic signed [15:0]   r_field_mem [MAX_SPINS];
    logic [MAX_SPINS-1:0] r_spin_mem [MAX_REPLICAS];
    logic [MAX_REPLICAS-1:0] r_row_vld;
    logic signed [15:0]   r_coup_rd;
    logic signed [15:0]   r_field_rd;
    logic [MAX_SPINS-1:0] r_spin_rd;

    // update working registers
    logic [MAX_SPINS-1:0] r_row;
    logic                 r_su;
    logic                 r_sd;
    logic [SPIN_W-1:0]    r_j;
    logic [SPIN_W-1:0]    r_jd;
    logic signed [31:0]   r_dh;
    logic signed [48:0]   r_prod;
    logic                 r_res_sv;
    logic                 r_res_fl;
    logic                 r_out_sv;
    logic                 r_out_fl;

    logic [SCNT_W-1:0]    ns;
    logic [TCNT_W-1:0]    nt;
    logic [REP_W-1:0]     rep_up;
    logic [REP_W-1:0]     rep_dn;
    logic [REP_W-1:0]     spin_raddr;
    logic                 spin_re;
    logic                 spin_we;
    logic [MAX_SPINS-1:0] spin_wdata;
    logic [MAX_SPINS-1:0] bit_mask;
    logic                 coup_re;
    logic [SPIN_W-1:0]    coup_j;
    logic signed [33:0]   acc_sum;
    logic signed [20:0]   tun_half;
    logic signed [33:0]   tun;
    logic signed [31:0]   dh_dbl;
    logic                 self_bit;
    logic signed [16:0]   beta_s;
    logic signed [49:0]   lhs;
    logic signed [49:0]   rhs;
    logic                 flip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcnt  <= TCNT_W'(MAX_REPLICAS);
            r_scnt  <= SCNT_W'(MAX_SPINS);
            r_jperp <= '0;
            r_beta  <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TROTTER: r_tcnt  <= i_cfg_data[TCNT_W-1:0];
                CFG_SPINS:   r_scnt  <= i_cfg_data[SCNT_W-1:0];
                CFG_JPERP:   r_jperp <= i_cfg_data;
                CFG_BETA:    r_beta  <= i_cfg_data;
                default:     r_beta  <= r_beta;
            endcase
        end
    end

    // counts saturated into the usable range
    assign ns = (r_scnt == '0) ? SCNT_W'(1)
              : (r_scnt > SCNT_W'(MAX_SPINS)) ? SCNT_W'(MAX_SPINS) : r_scnt;
    assign nt = (r_tcnt == '0) ? TCNT_W'(1)
              : (r_tcnt > TCNT_W'(MAX_REPLICAS)) ? TCNT_W'(MAX_REPLICAS) : r_tcnt;

    // ring neighbors
    assign rep_up = (r_ri == '0) ? REP_W'(nt - TCNT_W'(1)) : r_ri - REP_W'(1);
    assign rep_dn = ({1'b0, r_ri} == nt - TCNT_W'(1)) ? '0 : r_ri + REP_W'(1);

    assign o_stat.kind     = r_kind;
    assign o_stat.in_range = ({1'b0, r_si} < ns) && ({1'b0, r_ri} < nt);
    assign o_stat.last     = ({1'b0, r_jd} == ns - SCNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= i_kind;
            r_si   <= i_spin_index;
            r_pi   <= i_partner_index;
            r_ri   <= i_replica_index;
            r_lv   <= i_load_value;
            r_rnd  <= i_log_random;
        end
    end

    // coupling store
    assign coup_re = i_cmd.acc_start | i_cmd.acc;
    assign coup_j  = i_cmd.acc_start ? '0 : r_j;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_coup) begin
            r_coup_mem[{r_si, r_pi}] <= r_lv;
        end
        if (coup_re) begin
            r_coup_rd <= r_coup_mem[{r_si, coup_j}];
        end
    end

    // field store
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_field) begin
            r_field_mem[r_si] <= r_lv;
        end
        if (i_cmd.rd_row) begin
            r_field_rd <= r_field_mem[r_si];
        end
    end

    // spin store, one row per replica, unwritten rows read as zero
    assign spin_re    = i_cmd.rd_row | i_cmd.rd_up | i_cmd.rd_dn;
    assign spin_raddr = i_cmd.rd_up ? rep_up : (i_cmd.rd_dn ? rep_dn : r_ri);
    assign bit_mask   = MAX_SPINS'(1) << r_si;
    assign spin_we    = i_cmd.wr_spin | (i_cmd.cmp & flip);
    assign spin_wdata = i_cmd.wr_spin
                      ? ((r_spin_rd & ~bit_mask) | (r_lv[0] ? bit_mask : '0))
                      : (r_row ^ bit_mask);

    always_ff @(posedge i_clk) begin
        if (spin_we) begin
            r_spin_mem[r_ri] <= spin_wdata;
        end
        if (spin_re) begin
            r_spin_rd <= r_row_vld[spin_raddr] ? r_spin_mem[spin_raddr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (spin_we) begin
            r_row_vld[r_ri] <= 1'b1;
        end
    end

    // energy arithmetic
    assign acc_sum  = r_row[r_jd] ? (34'(r_dh) + 34'(r_coup_rd))
                                  : (34'(r_dh) - 34'(r_coup_rd));
    assign tun_half = r_jperp * signed'({1'b0, nt});
    assign tun      = 34'(tun_half) <<< 1;
    assign dh_dbl   = sat32(34'(r_dh) <<< 1);
    assign self_bit = r_row[r_si];
    assign beta_s   = signed'({1'b0, r_beta});
    assign lhs      = -50'(r_prod);
    assign rhs      = 50'(r_rnd) <<< 4;
    assign flip     = (lhs > rhs);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_row) begin
            r_row <= r_spin_rd;
            r_dh  <= 32'(r_field_rd);
        end
        if (i_cmd.cap_su) begin
            r_su <= r_spin_rd[r_si];
        end
        if (i_cmd.acc_start) begin
            r_j  <= SPIN_W'(1);
            r_jd <= '0;
        end
        if (i_cmd.acc) begin
            r_sd  <= r_spin_rd[r_si];
            r_dh  <= sat32(acc_sum);
            r_jd  <= r_j;
            r_j   <= r_j + SPIN_W'(1);
        end
        if (i_cmd.tun && (r_su == r_sd)) begin
            r_dh <= r_su ? sat32(34'(r_dh) - tun) : sat32(34'(r_dh) + tun);
        end
        if (i_cmd.dbl) begin
            r_dh <= self_bit ? dh_dbl : sat32(-34'(dh_dbl));
        end
        if (i_cmd.mul) begin
            r_prod <= beta_s * r_dh;
        end
    end

    // result and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_sv <= 1'b0;
            r_res_fl <= 1'b0;
        end else if (i_cmd.accept) begin
            r_res_sv <= 1'b0;
            r_res_fl <= 1'b0;
        end else if (i_cmd.cap_read) begin
            r_res_sv <= r_spin_rd[r_si];
        end else if (i_cmd.cmp) begin
            r_res_sv <= self_bit ^ flip;
            r_res_fl <= flip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_sv <= r_res_sv;
            r_out_fl <= r_res_fl;
        end
    end

    assign o_spin_value = r_out_sv;
    assign o_flipped    = r_out_fl;

endmodule

FILE: design/quantum_annealing_spin_update.sv
// top level: ising spin store with metropolis spin update on a replica ring
// throughput: one word at a time; an update is bound by the coupling store
//   read port, one coupling per cycle
// reset: synchronous active low; registers return to 8, 64, 0, 256 and the
//   spin store reads as all zero at once through per-row valid bits
module quantum_annealing_spin_update import qasu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    // input word
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_kind,
    input  logic [SPIN_W-1:0]  i_spin_index,
    input  logic [SPIN_W-1:0]  i_partner_index,
    input  logic [REP_W-1:0]   i_replica_index,
    input  logic signed [15:0] i_load_value,
    input  logic signed [23:0] i_log_random,
    // output word
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_spin_value,
    output logic               o_flipped
);

    // controller drives the datapath through one command bundle per cycle
    t_cmd  cmd;
    // datapath reports the word kind, range check and end of accumulation
    t_stat stat;

    qasu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // stores, accumulator and flip decision; the output word register
    // lives here so a finished word can wait while the next one is taken
    qasu_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (i_kind),
        .i_spin_index    (i_spin_index),
        .i_partner_index (i_partner_index),
        .i_replica_index (i_replica_index),
        .i_load_value    (i_load_value),
        .i_log_random    (i_log_random),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_spin_value    (o_spin_value),
        .o_flipped       (o_flipped)
    );

endmodule

FILE: design/qasu_chk.sv
// port level checks for the spin update block
module qasu_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_spin_value,
    input logic o_flipped
);

    // output word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output word dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_spin_value) && $stable(o_flipped))
        else $error("output word changed while stalled");

    // one word in flight: busy right after acceptance
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again right after acceptance");

    // no result can appear the cycle after a word is taken
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("output word appeared too early");

endmodule

bind quantum_annealing_spin_update qasu_chk u_qasu_chk (.*);
